/* hw/rtl/smix_pkg.sv */
// Shared types, constants and helpers for the stereo mixer.
package smix_pkg;

  localparam int CHANNELS = 8;
  localparam int ACC_W    = 24;
  localparam int OPA_W    = 28;
  localparam int PROD_W   = 30;

  localparam logic [1:0] OP_LOAD  = 2'd0;
  localparam logic [1:0] OP_SAMP  = 2'd1;
  localparam logic [1:0] OP_READ  = 2'd2;
  localparam logic [1:0] OP_CLEAR = 2'd3;

  localparam logic [1:0] REG_SOLO = 2'd0;
  localparam logic [1:0] REG_ML   = 2'd1;
  localparam logic [1:0] REG_MR   = 2'd2;
  localparam logic [1:0] REG_MIX  = 2'd3;

  localparam logic [15:0] UNITY   = 16'd16384;
  localparam logic [15:0] MIX_DEF = 16'd5793;

  typedef struct packed {
    logic [1:0]         op;
    logic [2:0]         channel;
    logic signed [15:0] channel_sample;
    logic               frame_end;
    logic signed [15:0] return_left;
    logic signed [15:0] return_right;
    logic [15:0]        level_gain;
    logic [15:0]        pan_left_gain;
    logic [15:0]        pan_right_gain;
    logic [15:0]        send_gain;
    logic               mute_flag;
    logic               send_mute_flag;
  } in_item_t;

  typedef struct packed {
    logic signed [15:0] out_left;
    logic signed [15:0] out_right;
    logic signed [15:0] send_left;
    logic signed [15:0] send_right;
    logic [15:0]        peak_value;
    logic [3:0]         peak_index;
    logic               last;
  } out_item_t;

  function automatic logic signed [15:0] sat16(input logic signed [PROD_W-1:0] v);
    if (v > $signed(PROD_W'(32767))) return 16'sh7fff;
    if (v < -$signed(PROD_W'(32768))) return 16'sh8000;
    return v[15:0];
  endfunction

  function automatic logic signed [ACC_W-1:0] acc_add(input logic signed [ACC_W-1:0] a,
                                                      input logic signed [PROD_W-1:0] v);
    logic signed [PROD_W:0] s;
    s = (PROD_W+1)'(a) + (PROD_W+1)'(v);
    if (s > $signed((PROD_W+1)'(8388607))) return 24'sh7fffff;
    if (s < -$signed((PROD_W+1)'(8388608))) return 24'sh800000;
    return s[ACC_W-1:0];
  endfunction

  function automatic logic [15:0] mag16(input logic signed [PROD_W-1:0] v);
    logic [PROD_W-1:0] a;
    a = v[PROD_W-1] ? PROD_W'(-v) : PROD_W'(v);
    return (a > PROD_W'(65535)) ? 16'hffff : a[15:0];
  endfunction

endpackage

/* hw/rtl/smix_mac.sv */
// Shared gain multiplier with Q2.14 rounding and a registered result.
module smix_mac (
  input  logic                                clk,
  input  logic signed [smix_pkg::OPA_W-1:0]   a,
  input  logic [15:0]                         g,
  output logic signed [smix_pkg::PROD_W-1:0]  p
);
  import smix_pkg::*;

  logic signed [OPA_W+16:0] prod;

  assign prod = a * $signed({1'b0, g}) + (OPA_W+17)'(8192);

  always_ff @(posedge clk) begin
    p <= PROD_W'(prod >>> 14);
  end

endmodule

/* hw/rtl/stereo_mixer_with_send_and_meters_unit.sv */
// Stereo mixer with effect send and peak meters: sequencer, tables and output register.
// One shared 28x17 multiplier does every gain product, one per cycle. A load or
// clear is done on its transfer; after its transfer a sample steps through S0 to S6 when its
// channel is heard and only S0 when it is not, then F1 to F7 when it closes the frame;
// a peak readout sends 10 transfers, each held until the output side takes it, and
// the next one is sent only after that. A new item is taken only once the last result is gone.
module stereo_mixer_with_send_and_meters_unit (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  smix_pkg::in_item_t    in_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output smix_pkg::out_item_t   out_data,
  input  logic                  cfg_we,
  input  logic [1:0]            cfg_index,
  input  logic [15:0]           cfg_data
);
  import smix_pkg::*;

  localparam logic [3:0] ST_IDLE = 4'd0;
  localparam logic [3:0] ST_S0   = 4'd1;
  localparam logic [3:0] ST_S1   = 4'd2;
  localparam logic [3:0] ST_S2   = 4'd3;
  localparam logic [3:0] ST_S3   = 4'd4;
  localparam logic [3:0] ST_S4   = 4'd5;
  localparam logic [3:0] ST_S5   = 4'd6;
  localparam logic [3:0] ST_S6   = 4'd7;
  localparam logic [3:0] ST_F1   = 4'd8;
  localparam logic [3:0] ST_F2   = 4'd9;
  localparam logic [3:0] ST_F3   = 4'd10;
  localparam logic [3:0] ST_F4   = 4'd11;
  localparam logic [3:0] ST_F5   = 4'd12;
  localparam logic [3:0] ST_F6   = 4'd13;
  localparam logic [3:0] ST_F7   = 4'd14;
  localparam logic [3:0] ST_RD   = 4'd15;

  logic [3:0] state;
  logic [3:0] sel;
  in_item_t   item;

  logic signed [3:0] solo;
  logic [15:0] master_left, master_right, mix_factor;

  logic [15:0] chan_level     [CHANNELS];
  logic [15:0] chan_pan_left  [CHANNELS];
  logic [15:0] chan_pan_right [CHANNELS];
  logic [15:0] chan_send      [CHANNELS];
  logic        chan_mute      [CHANNELS];
  logic        chan_send_mute [CHANNELS];
  logic [15:0] chan_peak      [CHANNELS];
  logic [15:0] bus_peak       [2];

  logic signed [ACC_W-1:0] acc_ol, acc_or, acc_sl, acc_sr;
  logic signed [PROD_W-1:0] sig, lval, rval, p;
  logic signed [15:0] res_ol, res_or, res_sl;

  logic signed [OPA_W-1:0] opa;
  logic [15:0] opg;
  logic [2:0]  ci;
  logic        heard;

  assign ci       = sel[2:0];
  assign in_ready = (state == ST_IDLE) && !out_valid;
  assign heard    = solo[3] ? !chan_mute[ci] : (solo == $signed({1'b0, ci}));

  always_comb begin
    opa = '0;
    opg = '0;
    case (state)
      ST_S1: begin opa = OPA_W'(item.channel_sample); opg = chan_level[ci]; end
      ST_S2: begin opa = OPA_W'(p); opg = chan_pan_left[ci]; end
      ST_S3: begin opa = OPA_W'(sig); opg = chan_pan_right[ci]; end
      ST_S4: begin opa = OPA_W'(lval); opg = chan_send[ci]; end
      ST_S5: begin opa = OPA_W'(rval); opg = chan_send[ci]; end
      ST_F1: begin
        opa = OPA_W'(acc_ol) + OPA_W'(item.return_left);
        opg = master_left;
      end
      ST_F2: begin opa = OPA_W'(p); opg = mix_factor; end
      ST_F3: begin
        opa = OPA_W'(acc_or) + OPA_W'(item.return_right);
        opg = master_right;
      end
      ST_F4: begin opa = OPA_W'(p); opg = mix_factor; end
      ST_F5: begin opa = OPA_W'(acc_sl); opg = mix_factor; end
      ST_F6: begin opa = OPA_W'(acc_sr); opg = mix_factor; end
      default: begin opa = '0; opg = '0; end
    endcase
  end

  smix_mac u_mac (.clk(clk), .a(opa), .g(opg), .p(p));

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      sel          <= '0;
      out_valid    <= 1'b0;
      solo         <= -4'sd1;
      master_left  <= UNITY;
      master_right <= UNITY;
      mix_factor   <= MIX_DEF;
      acc_ol       <= '0;
      acc_or       <= '0;
      acc_sl       <= '0;
      acc_sr       <= '0;
      bus_peak[0]  <= '0;
      bus_peak[1]  <= '0;
      for (int i = 0; i < CHANNELS; i++) begin
        chan_level[i]     <= UNITY;
        chan_pan_left[i]  <= UNITY;
        chan_pan_right[i] <= UNITY;
        chan_send[i]      <= '0;
        chan_mute[i]      <= 1'b0;
        chan_send_mute[i] <= 1'b0;
        chan_peak[i]      <= '0;
      end
    end else begin
      if (out_valid && out_ready) out_valid <= 1'b0;
      if (cfg_we) begin
        unique case (cfg_index)
          REG_SOLO: solo         <= $signed(cfg_data[3:0]);
          REG_ML:   master_left  <= cfg_data;
          REG_MR:   master_right <= cfg_data;
          REG_MIX:  mix_factor   <= cfg_data;
          default:  ;
        endcase
      end
      unique case (state)
        ST_IDLE: if (in_valid && in_ready) begin
          item <= in_data;
          sel  <= (in_data.op == OP_READ) ? 4'd0 : {1'b0, in_data.channel};
          unique case (in_data.op)
            OP_LOAD: begin
              chan_level[in_data.channel]     <= in_data.level_gain;
              chan_pan_left[in_data.channel]  <= in_data.pan_left_gain;
              chan_pan_right[in_data.channel] <= in_data.pan_right_gain;
              chan_send[in_data.channel]      <= in_data.send_gain;
              chan_mute[in_data.channel]      <= in_data.mute_flag;
              chan_send_mute[in_data.channel] <= in_data.send_mute_flag;
            end
            OP_SAMP: state <= ST_S0;
            OP_READ: state <= ST_RD;
            OP_CLEAR: begin
              for (int i = 0; i < CHANNELS; i++) chan_peak[i] <= '0;
              bus_peak[0] <= '0;
              bus_peak[1] <= '0;
            end
            default: ;
          endcase
        end
        ST_S0: state <= heard ? ST_S1 : (item.frame_end ? ST_F1 : ST_IDLE);
        ST_S1: state <= ST_S2;
        ST_S2: begin
          sig <= p;
          if (mag16(p) > chan_peak[ci]) chan_peak[ci] <= mag16(p);
          state <= ST_S3;
        end
        ST_S3: begin
          lval   <= p;
          acc_ol <= acc_add(acc_ol, p);
          state  <= ST_S4;
        end
        ST_S4: begin
          rval   <= p;
          acc_or <= acc_add(acc_or, p);
          state  <= ST_S5;
        end
        ST_S5: begin
          if (!chan_send_mute[ci]) acc_sl <= acc_add(acc_sl, p);
          state <= ST_S6;
        end
        ST_S6: begin
          if (!chan_send_mute[ci]) acc_sr <= acc_add(acc_sr, p);
          state <= item.frame_end ? ST_F1 : ST_IDLE;
        end
        ST_F1: state <= ST_F2;
        ST_F2: state <= ST_F3;
        ST_F3: begin res_ol <= sat16(p); state <= ST_F4; end
        ST_F4: state <= ST_F5;
        ST_F5: begin res_or <= sat16(p); state <= ST_F6; end
        ST_F6: begin res_sl <= sat16(p); state <= ST_F7; end
        ST_F7: begin
          out_data.out_left   <= res_ol;
          out_data.out_right  <= res_or;
          out_data.send_left  <= res_sl;
          out_data.send_right <= sat16(p);
          out_data.peak_value <= '0;
          out_data.peak_index <= '0;
          out_data.last       <= 1'b1;
          out_valid           <= 1'b1;
          if (mag16(PROD_W'(res_ol)) > bus_peak[0]) bus_peak[0] <= mag16(PROD_W'(res_ol));
          if (mag16(PROD_W'(res_or)) > bus_peak[1]) bus_peak[1] <= mag16(PROD_W'(res_or));
          acc_ol <= '0;
          acc_or <= '0;
          acc_sl <= '0;
          acc_sr <= '0;
          state  <= ST_IDLE;
        end
        ST_RD: if (!out_valid) begin
          out_data.out_left   <= '0;
          out_data.out_right  <= '0;
          out_data.send_left  <= '0;
          out_data.send_right <= '0;
          out_data.peak_index <= sel;
          out_data.last       <= (sel == 4'(CHANNELS + 1));
          if (sel < 4'(CHANNELS))      out_data.peak_value <= chan_peak[ci];
          else if (sel == 4'(CHANNELS)) out_data.peak_value <= bus_peak[0];
          else                          out_data.peak_value <= bus_peak[1];
          out_valid <= 1'b1;
          if (sel == 4'(CHANNELS + 1)) begin
            for (int i = 0; i < CHANNELS; i++) chan_peak[i] <= '0;
            bus_peak[0] <= '0;
            bus_peak[1] <= '0;
            state <= ST_IDLE;
          end else begin
            sel <= sel + 4'd1;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  a_frame_out: assert property (@(posedge clk) disable iff (rst)
    state == ST_F7 |=> out_valid) else $error("frame result not presented");
  a_busy_out: assert property (@(posedge clk) disable iff (rst)
    in_ready |-> !out_valid) else $error("input taken while result pending");
  a_readout_run: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_data.last |-> state == ST_RD) else $error("readout run broken");

endmodule
